// File: rtl/core/v3au_pkg.sv
// Shared types, constants and the saturating clamp for the vector arithmetic unit.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package v3au_pkg;

   localparam int WORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   // fixed field geometry
   localparam int ELEM_W     = 32;
   localparam int OP_W       = 3;
   localparam int PROD_W     = 2 * ELEM_W;
   localparam int WIDE_W     = 2 * ELEM_W + 3;
   localparam int REQ_DATA_W = 7 * ELEM_W;
   localparam int RSP_DATA_W = 4 * ELEM_W;
   localparam int RSP_USER_W = 2;
   localparam int USER_SAT_BIT  = 0;
   localparam int USER_DERR_BIT = 1;
   localparam int LANES      = 3;

   // pipeline geometry
   localparam int ROOT_STEPS = ELEM_W;
   localparam int SQRT_LAT   = ROOT_STEPS + 2;
   localparam int DIV_STEPS  = ELEM_W;
   localparam int DIV_LAT    = DIV_STEPS + 2;
   localparam int PIPE_LAT   = 1 + SQRT_LAT + DIV_LAT + 1;

   // operation codes
   localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
   localparam logic [OP_W-1:0] OP_SUB   = 3'd1;
   localparam logic [OP_W-1:0] OP_SCALE = 3'd2;
   localparam logic [OP_W-1:0] OP_DIV   = 3'd3;
   localparam logic [OP_W-1:0] OP_DOT   = 3'd4;
   localparam logic [OP_W-1:0] OP_CROSS = 3'd5;
   localparam logic [OP_W-1:0] OP_NORM  = 3'd6;
   localparam logic [OP_W-1:0] OP_UNIT  = 3'd7;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [WIDE_W-1:0] wide_type;

   typedef struct packed {
      logic     sat;
      elem_type val;
   } clamp_type;

   // per-lane result handed to the merge stage
   typedef struct packed {
      logic     sat;
      logic     derr;
      elem_type val;
   } lane_out_type;

   // largest representable value for a given word width (capped at 32 bits)
   function automatic wide_type max_of(input int word_w);
      int eff;
      eff = (word_w > ELEM_W) ? ELEM_W : word_w;
      return (wide_type'(1) <<< (eff - 1)) - wide_type'(1);
   endfunction

   function automatic clamp_type sat_clamp(input wide_type v, input wide_type max_v);
      clamp_type res;
      wide_type  min_v;
      min_v = -max_v - wide_type'(1);
      if (v > max_v) begin
         res.sat = 1'b1;
         res.val = max_v[ELEM_W-1:0];
      end else if (v < min_v) begin
         res.sat = 1'b1;
         res.val = min_v[ELEM_W-1:0];
      end else begin
         res.sat = 1'b0;
         res.val = v[ELEM_W-1:0];
      end
      return res;
   endfunction

endpackage

// File: rtl/core/v3au_sqrt.sv
// Pipelined rounded integer square root of the squared vector length.
// One result bit per stage; depends on v3au_pkg.
`timescale 1ns / 1ps

module v3au_sqrt (
   input  logic                          clock,
   input  logic                          adv,
   input  logic [v3au_pkg::PROD_W-1:0]   sq_x,
   input  logic [v3au_pkg::PROD_W-1:0]   sq_y,
   input  logic [v3au_pkg::PROD_W-1:0]   sq_z,
   output logic [v3au_pkg::ELEM_W:0]     root
);
   import v3au_pkg::*;

   localparam int REM_W = PROD_W + 2;

   logic [REM_W-1:0]  rem_ff [0:ROOT_STEPS];
   logic [ELEM_W-1:0] rt_ff  [0:ROOT_STEPS];
   logic [ELEM_W:0]   root_ff;
   logic [ELEM_W:0]   root_in;

   // squared length
   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= REM_W'(sq_x) + REM_W'(sq_y) + REM_W'(sq_z);
         rt_ff[0]  <= '0;
      end
   end

   // digit-by-digit root, one bit per stage, MSB first
   for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_step
      localparam int K = ROOT_STEPS - 1 - g;
      logic [REM_W-1:0] trial;
      logic             fits;
      assign trial = (REM_W'(rt_ff[g]) << (K + 1)) + (REM_W'(1) << (2 * K));
      assign fits  = rem_ff[g] >= trial;
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[g+1] <= fits ? rem_ff[g] - trial : rem_ff[g];
            rt_ff[g+1]  <= fits ? (rt_ff[g] | (ELEM_W'(1) << K)) : rt_ff[g];
         end
      end
   end

   // round to nearest: bump when the remainder exceeds the root
   assign root_in = {1'b0, rt_ff[ROOT_STEPS]} +
                    ((rem_ff[ROOT_STEPS] > REM_W'(rt_ff[ROOT_STEPS])) ?
                     (ELEM_W+1)'(1) : '0);

   always_ff @(posedge clock) begin
      if (adv) begin
         root_ff <= root_in;
      end
   end

   assign root = root_ff;

endmodule

// File: rtl/core/v3au_lane.sv
// One component lane: products, elementwise results and a pipelined divider.
// Depends on v3au_pkg; takes the shared root from v3au_sqrt.
`timescale 1ns / 1ps

module v3au_lane #(
   parameter int WORD_WIDTH = v3au_pkg::WORD_WIDTH_DEF,
   parameter int FRAC_BITS  = v3au_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          adv,
   input  logic [v3au_pkg::OP_W-1:0]     in_op,
   input  v3au_pkg::elem_type            a_i,
   input  v3au_pkg::elem_type            b_i,
   input  v3au_pkg::elem_type            a_j,
   input  v3au_pkg::elem_type            a_k,
   input  v3au_pkg::elem_type            b_j,
   input  v3au_pkg::elem_type            b_k,
   input  v3au_pkg::elem_type            scalar,
   input  logic [v3au_pkg::ELEM_W:0]     root,
   output logic [v3au_pkg::PROD_W-1:0]   sq,
   output v3au_pkg::prod_type            prod_ab,
   output v3au_pkg::lane_out_type        lane_out
);
   import v3au_pkg::*;

   localparam wide_type MAX_V = max_of(WORD_WIDTH);
   localparam wide_type MIN_V = -MAX_V - wide_type'(1);
   localparam wide_type HALF  = wide_type'(1) <<< (FRAC_BITS - 1);
   localparam int SUM_W = ELEM_W + 1;
   localparam int NUM_W = PROD_W;
   localparam int DEN_W = ELEM_W + 1;
   localparam int CMP_W = DEN_W + DIV_STEPS;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      clamp_type         simple;
      elem_type          a;
      logic              sneg;
      logic [ELEM_W-1:0] smag;
      logic              szero;
   } dly_type;

   typedef struct packed {
      logic [NUM_W-1:0]  rem;
      logic [DEN_W-1:0]  den;
      logic [ELEM_W-1:0] q;
      logic              ovf;
      logic [OP_W-1:0]   op;
      clamp_type         simple;
      logic              a_neg;
      logic              a_zero;
      logic              neg;
      logic              den_zero;
   } div_type;

   // stage 1: operands, sums and products
   logic [OP_W-1:0]          op1_ff;
   elem_type                 a1_ff;
   elem_type                 s1_ff;
   logic signed [SUM_W-1:0]  sum1_ff;
   logic signed [SUM_W-1:0]  dif1_ff;
   prod_type                 ps1_ff;
   prod_type                 pb1_ff;
   prod_type                 psq1_ff;
   prod_type                 c1_ff;
   prod_type                 c2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         op1_ff  <= in_op;
         a1_ff   <= a_i;
         s1_ff   <= scalar;
         sum1_ff <= SUM_W'(a_i) + SUM_W'(b_i);
         dif1_ff <= SUM_W'(a_i) - SUM_W'(b_i);
         ps1_ff  <= PROD_W'(a_i) * PROD_W'(scalar);
         pb1_ff  <= PROD_W'(a_i) * PROD_W'(b_i);
         psq1_ff <= PROD_W'(a_i) * PROD_W'(a_i);
         c1_ff   <= PROD_W'(a_j) * PROD_W'(b_k);
         c2_ff   <= PROD_W'(a_k) * PROD_W'(b_j);
      end
   end

   assign sq      = $unsigned(psq1_ff);
   assign prod_ab = pb1_ff;

   // stage 2: elementwise results, rounded and clamped
   clamp_type         simple_in;
   logic [ELEM_W-1:0] smag_in;
   dly_type           dly_in;
   dly_type           dly_ff [0:SQRT_LAT-1];

   always_comb begin
      case (op1_ff)
         OP_ADD:   simple_in = sat_clamp(wide_type'(sum1_ff), MAX_V);
         OP_SUB:   simple_in = sat_clamp(wide_type'(dif1_ff), MAX_V);
         OP_SCALE: simple_in = sat_clamp((wide_type'(ps1_ff) + HALF) >>> FRAC_BITS, MAX_V);
         OP_CROSS: simple_in = sat_clamp((wide_type'(c1_ff) - wide_type'(c2_ff) + HALF)
                                         >>> FRAC_BITS, MAX_V);
         default:  simple_in = '0;
      endcase
      smag_in       = s1_ff[ELEM_W-1] ? ELEM_W'(-s1_ff) : ELEM_W'(s1_ff);
      dly_in.op     = op1_ff;
      dly_in.simple = simple_in;
      dly_in.a      = a1_ff;
      dly_in.sneg   = s1_ff[ELEM_W-1];
      dly_in.smag   = smag_in;
      dly_in.szero  = (s1_ff == '0);
   end

   // wait for the shared root
   always_ff @(posedge clock) begin
      if (adv) begin
         dly_ff[0] <= dly_in;
         for (int i = 1; i < SQRT_LAT; i++) begin
            dly_ff[i] <= dly_ff[i-1];
         end
      end
   end

   // divider setup: pick divisor, form rounded dividend
   dly_type           dl;
   logic [DEN_W-1:0]  den_sel;
   logic [ELEM_W-1:0] mag;
   div_type           prep_in;
   div_type           div_ff [0:DIV_STEPS];

   always_comb begin
      dl      = dly_ff[SQRT_LAT-1];
      den_sel = (dl.op == OP_UNIT) ? root : DEN_W'(dl.smag);
      mag     = dl.a[ELEM_W-1] ? ELEM_W'(-dl.a) : ELEM_W'(dl.a);
      prep_in.rem      = (NUM_W'(mag) << FRAC_BITS) + NUM_W'(den_sel >> 1);
      prep_in.den      = den_sel;
      prep_in.q        = '0;
      prep_in.ovf      = 1'b0;
      prep_in.op       = dl.op;
      prep_in.simple   = dl.simple;
      prep_in.a_neg    = dl.a[ELEM_W-1];
      prep_in.a_zero   = (dl.a == '0);
      prep_in.neg      = dl.a[ELEM_W-1] ^ ((dl.op == OP_DIV) & dl.sneg);
      prep_in.den_zero = (dl.op == OP_UNIT) ? (root == '0) : dl.szero;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff[0] <= prep_in;
      end
   end

   // restoring division, one quotient bit per stage; first stage flags overflow
   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
      localparam int K = DIV_STEPS - 1 - g;
      logic [CMP_W-1:0] trial;
      logic             fits;
      logic             ovf_in;
      div_type          nxt;
      assign trial  = CMP_W'(div_ff[g].den) << K;
      assign fits   = CMP_W'(div_ff[g].rem) >= trial;
      assign ovf_in = (g == 0) ? (CMP_W'(div_ff[g].rem) >=
                                  (CMP_W'(div_ff[g].den) << DIV_STEPS))
                               : div_ff[g].ovf;
      always_comb begin
         nxt     = div_ff[g];
         nxt.ovf = ovf_in;
         if (fits) begin
            nxt.rem  = div_ff[g].rem - trial[NUM_W-1:0];
            nxt.q[K] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            div_ff[g+1] <= nxt;
         end
      end
   end

   // finish: sign, saturation and the zero-divisor cases
   div_type      df;
   wide_type     q_w;
   wide_type     nq_w;
   clamp_type    quo;
   lane_out_type out_in;
   lane_out_type out_ff;

   always_comb begin
      df   = div_ff[DIV_STEPS];
      q_w  = wide_type'({1'b0, df.q});
      nq_w = -q_w;
      if (df.a_zero) begin
         quo = '0;
      end else if (!df.neg) begin
         if (df.ovf || q_w > MAX_V) quo = '{sat: 1'b1, val: MAX_V[ELEM_W-1:0]};
         else                       quo = '{sat: 1'b0, val: q_w[ELEM_W-1:0]};
      end else begin
         if (df.ovf || q_w > MAX_V + wide_type'(1))
            quo = '{sat: 1'b1, val: MIN_V[ELEM_W-1:0]};
         else
            quo = '{sat: 1'b0, val: nq_w[ELEM_W-1:0]};
      end
      out_in = '0;
      case (df.op)
         OP_ADD, OP_SUB, OP_SCALE, OP_CROSS: begin
            out_in.val = df.simple.val;
            out_in.sat = df.simple.sat;
         end
         OP_DIV: begin
            if (df.den_zero) begin
               out_in.derr = 1'b1;
               if (!df.a_zero) begin
                  out_in.sat = 1'b1;
                  out_in.val = df.a_neg ? MIN_V[ELEM_W-1:0] : MAX_V[ELEM_W-1:0];
               end
            end else begin
               out_in.val = quo.val;
               out_in.sat = quo.sat;
            end
         end
         OP_UNIT: begin
            if (df.den_zero) begin
               out_in.derr = 1'b1;
            end else begin
               out_in.val = quo.val;
               out_in.sat = quo.sat;
            end
         end
         default: out_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign lane_out = out_ff;

endmodule

// File: rtl/core/v3au_merge.sv
// Merge stage: dot product across lanes, norm selection and the output register.
// Depends on v3au_pkg; fed by the three lanes and v3au_sqrt.
`timescale 1ns / 1ps

module v3au_merge #(
   parameter int WORD_WIDTH = v3au_pkg::WORD_WIDTH_DEF,
   parameter int FRAC_BITS  = v3au_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              adv,
   input  logic [v3au_pkg::OP_W-1:0]         in_op,
   input  v3au_pkg::prod_type                pb_x,
   input  v3au_pkg::prod_type                pb_y,
   input  v3au_pkg::prod_type                pb_z,
   input  logic [v3au_pkg::ELEM_W:0]         root,
   input  v3au_pkg::lane_out_type            lane_x,
   input  v3au_pkg::lane_out_type            lane_y,
   input  v3au_pkg::lane_out_type            lane_z,
   output logic [v3au_pkg::RSP_DATA_W-1:0]   rsp_data,
   output logic [v3au_pkg::RSP_USER_W-1:0]   rsp_user
);
   import v3au_pkg::*;

   localparam wide_type MAX_V  = max_of(WORD_WIDTH);
   localparam wide_type HALF   = wide_type'(1) <<< (FRAC_BITS - 1);
   localparam int OP_LINE  = SQRT_LAT + 1;
   localparam int DOT_LINE = SQRT_LAT - 1;

   logic [OP_W-1:0] op_ff [0:OP_LINE-1];
   wide_type        dot_sum_ff;
   clamp_type       dot_ff [0:DOT_LINE-1];
   clamp_type       scl_in;
   clamp_type       scl_ff [0:DIV_LAT-1];

   // operation code, kept until the scalar select
   always_ff @(posedge clock) begin
      if (adv) begin
         op_ff[0] <= in_op;
         for (int i = 1; i < OP_LINE; i++) begin
            op_ff[i] <= op_ff[i-1];
         end
      end
   end

   // dot product: sum of lane products, then round and clamp
   always_ff @(posedge clock) begin
      if (adv) begin
         dot_sum_ff <= wide_type'(pb_x) + wide_type'(pb_y) + wide_type'(pb_z) + HALF;
         dot_ff[0]  <= sat_clamp(dot_sum_ff >>> FRAC_BITS, MAX_V);
         for (int i = 1; i < DOT_LINE; i++) begin
            dot_ff[i] <= dot_ff[i-1];
         end
      end
   end

   // scalar result select once the root is ready
   always_comb begin
      case (op_ff[OP_LINE-1])
         OP_DOT:  scl_in = dot_ff[DOT_LINE-1];
         OP_NORM: scl_in = sat_clamp(wide_type'(root), MAX_V);
         default: scl_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         scl_ff[0] <= scl_in;
         for (int i = 1; i < DIV_LAT; i++) begin
            scl_ff[i] <= scl_ff[i-1];
         end
      end
   end

   // output register
   logic [RSP_DATA_W-1:0] data_ff;
   logic [RSP_USER_W-1:0] user_ff;
   logic [RSP_USER_W-1:0] user_in;

   always_comb begin
      user_in                = '0;
      user_in[USER_SAT_BIT]  = lane_x.sat | lane_y.sat | lane_z.sat | scl_ff[DIV_LAT-1].sat;
      user_in[USER_DERR_BIT] = lane_x.derr;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= {scl_ff[DIV_LAT-1].val, lane_z.val, lane_y.val, lane_x.val};
         user_ff <= user_in;
      end
   end

   assign rsp_data = data_ff;
   assign rsp_user = user_ff;

endmodule

// File: rtl/core/vector3_arithmetic_unit_core.sv
// Top level of the three-component fixed-point vector ALU.
// Depends on v3au_pkg, v3au_lane, v3au_sqrt and v3au_merge.
`timescale 1ns / 1ps

// Usage:
//   req channel carries one item per transfer: tdata holds a_x, a_y, a_z,
//   b_x, b_y, b_z and scalar (32 bits each, a_x lowest); tuser holds the
//   operation (add, sub, scale, divide, dot, cross, norm, normalise).
//   rsp channel returns exactly one result per item, in order: tdata holds
//   r_x, r_y, r_z, r_scalar (r_x lowest); tuser bit 0 is saturated,
//   bit 1 is divide_error.
//   From the req transfer to rsp_tvalid an item passes through products,
//   a 32-stage root, a 32-stage divider per lane, merge and the output
//   register. All operations take the same path.
//   Throughput is one item per cycle unless rsp_tready stalls the pipeline;
//   three lanes work on x, y and z side by side and share the root unit.
//   When the receiver holds rsp_tready low with a result waiting, the whole
//   pipeline freezes and req_tready drops until the result is taken.
//   Reset (synchronous, active high) empties the pipeline; no result is
//   pending afterwards. The block keeps no state between items.
module vector3_arithmetic_unit_core #(
   parameter int WORD_WIDTH = v3au_pkg::WORD_WIDTH_DEF,
   parameter int FRAC_BITS  = v3au_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, scalar
   input  logic [v3au_pkg::REQ_DATA_W-1:0]   req_tdata,
   // operation
   input  logic [v3au_pkg::OP_W-1:0]         req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // r_x, r_y, r_z, r_scalar
   output logic [v3au_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // saturated, divide_error
   output logic [v3au_pkg::RSP_USER_W-1:0]   rsp_tuser
);
   import v3au_pkg::*;

   logic                adv;
   logic [PIPE_LAT-1:0] vld_ff;
   logic [PIPE_LAT-1:0] vld_in;

   // global advance: move whenever the output slot is free or being taken
   assign adv        = !vld_ff[PIPE_LAT-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[PIPE_LAT-1];
   assign vld_in     = adv ? {vld_ff[PIPE_LAT-2:0], req_tvalid} : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // split the payload
   elem_type a_v [0:LANES-1];
   elem_type b_v [0:LANES-1];
   elem_type s_v;

   for (genvar i = 0; i < LANES; i++) begin : g_split
      assign a_v[i] = req_tdata[i*ELEM_W +: ELEM_W];
      assign b_v[i] = req_tdata[(LANES+i)*ELEM_W +: ELEM_W];
   end
   assign s_v = req_tdata[2*LANES*ELEM_W +: ELEM_W];

   // lanes
   logic [PROD_W-1:0] sq_v   [0:LANES-1];
   prod_type          pb_v   [0:LANES-1];
   lane_out_type      lane_v [0:LANES-1];
   logic [ELEM_W:0]   root;

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      v3au_lane #(
         .WORD_WIDTH (WORD_WIDTH),
         .FRAC_BITS  (FRAC_BITS)
      ) u_lane (
         .clock    (clock),
         .adv      (adv),
         .in_op    (req_tuser),
         .a_i      (a_v[i]),
         .b_i      (b_v[i]),
         .a_j      (a_v[(i+1)%LANES]),
         .a_k      (a_v[(i+2)%LANES]),
         .b_j      (b_v[(i+1)%LANES]),
         .b_k      (b_v[(i+2)%LANES]),
         .scalar   (s_v),
         .root     (root),
         .sq       (sq_v[i]),
         .prod_ab  (pb_v[i]),
         .lane_out (lane_v[i])
      );
   end

   // shared root of the squared length
   v3au_sqrt u_sqrt (
      .clock (clock),
      .adv   (adv),
      .sq_x  (sq_v[0]),
      .sq_y  (sq_v[1]),
      .sq_z  (sq_v[2]),
      .root  (root)
   );

   // merge and output register
   v3au_merge #(
      .WORD_WIDTH (WORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_merge (
      .clock    (clock),
      .adv      (adv),
      .in_op    (req_tuser),
      .pb_x     (pb_v[0]),
      .pb_y     (pb_v[1]),
      .pb_z     (pb_v[2]),
      .root     (root),
      .lane_x   (lane_v[0]),
      .lane_y   (lane_v[1]),
      .lane_z   (lane_v[2]),
      .rsp_data (rsp_tdata),
      .rsp_user (rsp_tuser)
   );

endmodule

// File: rtl/core/v3au_checker.sv
// Port-level checks on the vector ALU top level, bound to every instance.
// Depends on v3au_pkg and vector3_arithmetic_unit_core.
`timescale 1ns / 1ps

module v3au_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [v3au_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic [v3au_pkg::RSP_USER_W-1:0]   rsp_tuser
);
   import v3au_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp transfer changed while stalled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // input is taken exactly when the output slot moves
   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("req_tready out of step with output slot");

   // a divide error only comes from vector operations
   a_derr_scalar: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[USER_DERR_BIT] |->
         rsp_tdata[RSP_DATA_W-1 -: ELEM_W] == '0)
      else $error("divide error with nonzero scalar result");

endmodule

bind vector3_arithmetic_unit_core v3au_checker u_v3au_checker (.*);
